// ----- rtl/assert_macros.svh -----
// Assertion macros for the port-level checker of the heartbeat watchdog.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define HWT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heartbeat watchdog check failed");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define HWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heartbeat watchdog check failed");

`endif

// ----- rtl/hwt_pkg.sv -----
// Shared types and constants of the heartbeat watchdog table.
// No dependencies; the RTL files but the macro header use it by scoped names.
`default_nettype none

package hwt_pkg;

    localparam int CID_W   = 8;   // client_id on the input side
    localparam int PID_W   = 22;  // process id
    localparam int CNT_W   = 8;   // miss counter and threshold
    localparam int OCL_W   = 5;   // expired_client on the output side
    localparam int ACT_W   = 2;
    localparam int MODE_W  = 2;
    localparam int TDATA_W = 32;

    localparam int MAX_RESULTS = 32;
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    // Modulo unit: one quotient bit per cycle over a dividend one bit wider
    // than the counter.
    localparam int MOD_W  = CNT_W + 1;
    localparam int MOD_SW = $clog2(MOD_W + 1);

    localparam logic REQ_TICK      = 1'b0;
    localparam logic REQ_HEARTBEAT = 1'b1;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MODE      = 2'd1;
    localparam logic [1:0] REG_ENABLE    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RELOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WARNING  = 2'd2;

    localparam logic [ACT_W-1:0] ACT_RELOAD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SHUTDOWN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WARNING  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_PROMPT   = 2'd3;

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd3;

    typedef struct packed {
        logic             last;
        logic [PID_W-1:0] expired_proc_id;
        logic [ACT_W-1:0] action;
        logic [OCL_W-1:0] expired_client;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } mod_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/hwt_mod.sv -----
// Iterative remainder unit: one restoring step per cycle.
// Depends on hwt_pkg for widths and the request and response structs.
`default_nettype none

module hwt_mod
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hwt_pkg::mod_req_t req,
    output hwt_pkg::mod_rsp_t      rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [hwt_pkg::MOD_SW-1:0]     step_reg;
    logic [hwt_pkg::MOD_W-1:0]      dvd_reg;
    logic [hwt_pkg::CNT_W-1:0]      dvs_reg;
    logic [hwt_pkg::CNT_W-1:0]      rem_reg;
    logic [hwt_pkg::MOD_W-1:0]      trial;
    logic [hwt_pkg::CNT_W-1:0]      rem_next;

    // The partial remainder stays below the divisor, so the shifted value fits
    // in one bit more than the counter.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[hwt_pkg::MOD_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = hwt_pkg::CNT_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[hwt_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= hwt_pkg::MOD_SW'(hwt_pkg::MOD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - hwt_pkg::MOD_SW'(1);
            if (step_reg == hwt_pkg::MOD_SW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[hwt_pkg::MOD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/hwt_obuf.sv -----
// Output register of the result stream; it parts the table engine from the
// downstream stall. Depends on hwt_pkg for the result struct.
`default_nettype none

module hwt_obuf
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire hwt_pkg::res_t                  res,
    output logic                                ready,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [hwt_pkg::TDATA_W-1:0]         m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int PAY_W = hwt_pkg::OCL_W + hwt_pkg::ACT_W + hwt_pkg::PID_W;

    logic          full_reg;
    hwt_pkg::res_t data_reg;

    assign ready = !full_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (push)
        begin
            full_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = full_reg;
    assign m_axis_tdata  = {{(hwt_pkg::TDATA_W - PAY_W){1'b0}},
                            data_reg.expired_proc_id, data_reg.action,
                            data_reg.expired_client};
    assign m_axis_tlast  = data_reg.last;

endmodule

`default_nettype wire

// ----- rtl/heartbeat_watchdog_table.sv -----
// Heartbeat watchdog table, top level. Depends on hwt_pkg, hwt_mod and hwt_obuf.
//
// A heartbeat transfer (tuser 1) registers client client_id (1 to MODULES-1)
// with its process id, clears its miss counter and, on first sight, marks it
// present and running; other ids are dropped. A tick transfer (tuser 0), when
// enabled, walks every client entry in ascending order, advances the miss
// counter of each present client modulo the threshold, and sends one result
// per client whose counter wraps to zero, up to MAX_RESULTS per tick, the
// final one of the tick with tlast set. Client state lives in two synchronous
// RAMs (status and process id) with registered read data; presence bits sit
// in flip-flops and reset clears them at once, so no clearing pass follows
// reset. A heartbeat for a new client writes its status entry directly; one
// for a known client reads the entry first, then writes it back. A tick reads
// each present entry from RAM, then updates and writes it back, skips absent
// entries, and closes with a flush state. A counter whose increment reaches
// twice the threshold (only after the threshold was lowered) goes through the
// bit-serial remainder unit. The result register lets a tick go on while one
// result waits downstream; a second pending result stalls the walk.
// Configuration writes are always taken and are meant to happen while no
// tick is in progress.
`default_nettype none

module heartbeat_watchdog_table
#(
    parameter int MODULES = 32
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Input stream.
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [hwt_pkg::TDATA_W-1:0] s_axis_tdata,  // [7:0] client_id, [29:8] proc_id
    input  wire logic [0:0]                  s_axis_tuser,  // [0] req_type
    // Result stream.
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [hwt_pkg::TDATA_W-1:0]      m_axis_tdata,  // [4:0] expired_client,
                                                            // [6:5] action,
                                                            // [28:7] expired_proc_id
    output logic                             m_axis_tlast,  // last
    // Configuration write channel.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [7:0]                  cfg_data
);

    localparam int IDW    = $clog2(MODULES);
    localparam int CNT_W  = hwt_pkg::CNT_W;
    localparam int PID_W  = hwt_pkg::PID_W;
    localparam int STAT_W = CNT_W + 1;      // {running, miss counter}
    localparam int RCNT_W = hwt_pkg::RCNT_W;
    localparam logic [IDW-1:0] LAST_ID = IDW'(MODULES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HB_WR,
        S_TK_RD,
        S_TK_EVAL,
        S_TK_MOD,
        S_TK_FLUSH
    } state_t;

    // Control registers.
    state_t                      state_reg, state_next;
    logic [IDW-1:0]              idx_reg, idx_next;
    logic [MODULES-1:0]          present_reg, present_next;
    logic                        reload_lat_reg, reload_lat_next;
    logic                        shut_lat_reg, shut_lat_next;
    logic                        warn_lat_reg, warn_lat_next;
    logic                        hold_valid_reg, hold_valid_next;
    logic [RCNT_W-1:0]           rep_cnt_reg, rep_cnt_next;
    logic [CNT_W-1:0]            thr_reg, thr_next;
    logic [hwt_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic                        en_reg, en_next;

    // Payload registers.
    logic [IDW-1:0]              hb_idx_reg;
    hwt_pkg::res_t               hold_reg;
    logic                        hold_load;
    hwt_pkg::res_t               hold_new;

    // Memories and their ports.
    logic [STAT_W-1:0]           stat_mem [MODULES];
    logic [PID_W-1:0]            pid_mem [MODULES];
    logic                        rd_en;
    logic [IDW-1:0]              rd_addr;
    logic [STAT_W-1:0]           stat_q;
    logic [PID_W-1:0]            pid_q;
    logic                        stat_we;
    logic [IDW-1:0]              stat_wa;
    logic [STAT_W-1:0]           stat_wd;
    logic                        pid_we;

    // Input decode.
    logic                        in_fire;
    logic                        in_hb;
    logic [hwt_pkg::CID_W-1:0]   in_cid;
    logic [PID_W-1:0]            in_pid;
    logic [IDW-1:0]              in_idx;
    logic                        cid_ok;

    // Counter update.
    logic [CNT_W-1:0]            thr_eff;
    logic [CNT_W:0]              cnt_inc;
    logic [CNT_W:0]              thr_x1;
    logic [CNT_W:0]              thr_x2;
    logic                        slow;
    logic [CNT_W-1:0]            fast_cnt;
    logic [CNT_W-1:0]            cnt_new;
    logic                        eval_go;
    logic                        run_old;
    logic                        expire;
    logic                        report;
    logic                        stall;
    logic [hwt_pkg::ACT_W-1:0]   act;
    logic                        set_reload;
    logic                        set_shut;
    logic                        set_warn;

    // Submodule links.
    hwt_pkg::mod_req_t           mod_req;
    hwt_pkg::mod_rsp_t           mod_rsp;
    logic                        ob_push;
    logic                        ob_ready;
    hwt_pkg::res_t               ob_res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_hb         = (s_axis_tuser[0] == hwt_pkg::REQ_HEARTBEAT);
    assign in_cid        = s_axis_tdata[hwt_pkg::CID_W-1:0];
    assign in_pid        = s_axis_tdata[hwt_pkg::CID_W +: PID_W];
    assign in_idx        = IDW'(in_cid);
    assign cid_ok        = (in_cid != '0) && (32'(in_cid) < 32'(MODULES));

    // A threshold of zero behaves as one. Incremented counters below twice the threshold
    // wrap with one subtraction; from twice the threshold up they need the remainder unit.
    assign thr_eff  = (thr_reg == '0) ? CNT_W'(1) : thr_reg;
    assign cnt_inc  = {1'b0, stat_q[CNT_W-1:0]} + (CNT_W + 1)'(1);
    assign thr_x1   = {1'b0, thr_eff};
    assign thr_x2   = {thr_eff, 1'b0};
    assign slow     = (cnt_inc >= thr_x2);
    assign fast_cnt = (cnt_inc < thr_x1) ? cnt_inc[CNT_W-1:0] : CNT_W'(cnt_inc - thr_x1);
    assign cnt_new  = (state_reg == S_TK_MOD) ? mod_rsp.rem : fast_cnt;
    assign eval_go  = ((state_reg == S_TK_EVAL) && !slow) ||
                      ((state_reg == S_TK_MOD) && mod_rsp.done);

    assign run_old = stat_q[CNT_W];
    assign expire  = (cnt_new == '0);
    assign report  = expire && (rep_cnt_reg < RCNT_W'(hwt_pkg::MAX_RESULTS));
    // A new result needs the pending one moved to the output register first.
    assign stall   = report && hold_valid_reg && !ob_ready;

    // Reaction choice: each mode acts once, everything else is a prompt.
    always_comb
    begin
        act        = hwt_pkg::ACT_PROMPT;
        set_reload = 1'b0;
        set_shut   = 1'b0;
        set_warn   = 1'b0;
        case (mode_reg)
            hwt_pkg::MODE_RELOAD:
            begin
                if (run_old && !reload_lat_reg)
                begin
                    act        = hwt_pkg::ACT_RELOAD;
                    set_reload = 1'b1;
                end
            end
            hwt_pkg::MODE_SHUTDOWN:
            begin
                if (run_old && !shut_lat_reg)
                begin
                    act      = hwt_pkg::ACT_SHUTDOWN;
                    set_shut = 1'b1;
                end
            end
            hwt_pkg::MODE_WARNING:
            begin
                if (run_old && !warn_lat_reg)
                begin
                    act      = hwt_pkg::ACT_WARNING;
                    set_warn = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        hold_new.expired_client  = hwt_pkg::OCL_W'(idx_reg);
        hold_new.action          = act;
        hold_new.expired_proc_id = pid_q;
        hold_new.last            = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        present_next    = present_reg;
        reload_lat_next = reload_lat_reg;
        shut_lat_next   = shut_lat_reg;
        warn_lat_next   = warn_lat_reg;
        hold_valid_next = hold_valid_reg;
        rep_cnt_next    = rep_cnt_reg;
        thr_next        = thr_reg;
        mode_next       = mode_reg;
        en_next         = en_reg;
        hold_load       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        stat_we         = 1'b0;
        stat_wa         = idx_reg;
        stat_wd         = '0;
        pid_we          = 1'b0;
        ob_push         = 1'b0;
        ob_res          = hold_reg;
        ob_res.last     = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = cnt_inc;
        mod_req.divisor  = thr_eff;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hwt_pkg::REG_THRESHOLD: thr_next  = cfg_data;
                hwt_pkg::REG_MODE:      mode_next = cfg_data[hwt_pkg::MODE_W-1:0];
                hwt_pkg::REG_ENABLE:    en_next   = cfg_data[0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_hb && cid_ok)
                begin
                    pid_we = 1'b1;
                    if (present_reg[in_idx])
                    begin
                        // Known client: keep its running mark, so read it first.
                        rd_en      = 1'b1;
                        rd_addr    = in_idx;
                        state_next = S_HB_WR;
                    end
                    else
                    begin
                        stat_we              = 1'b1;
                        stat_wa              = in_idx;
                        stat_wd              = {1'b1, {CNT_W{1'b0}}};
                        present_next[in_idx] = 1'b1;
                    end
                end
                else if (in_fire && !in_hb && en_reg)
                begin
                    idx_next     = IDW'(1);
                    rep_cnt_next = '0;
                    state_next   = S_TK_RD;
                end
            end

            S_HB_WR:
            begin
                stat_we    = 1'b1;
                stat_wa    = hb_idx_reg;
                stat_wd    = {stat_q[CNT_W], {CNT_W{1'b0}}};
                state_next = S_IDLE;
            end

            S_TK_RD:
            begin
                if (present_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = S_TK_EVAL;
                end
                else if (idx_reg == LAST_ID)
                begin
                    state_next = S_TK_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + IDW'(1);
                end
            end

            S_TK_EVAL, S_TK_MOD:
            begin
                if ((state_reg == S_TK_EVAL) && slow)
                begin
                    mod_req.start = 1'b1;
                    state_next    = S_TK_MOD;
                end
                else if (eval_go && !stall)
                begin
                    stat_we = 1'b1;
                    stat_wd = {run_old && !expire, cnt_new};
                    if (expire)
                    begin
                        reload_lat_next = reload_lat_reg || set_reload;
                        shut_lat_next   = shut_lat_reg || set_shut;
                        warn_lat_next   = warn_lat_reg || set_warn;
                    end
                    if (report)
                    begin
                        ob_push         = hold_valid_reg;
                        hold_load       = 1'b1;
                        hold_valid_next = 1'b1;
                        rep_cnt_next    = rep_cnt_reg + RCNT_W'(1);
                    end
                    if (idx_reg == LAST_ID)
                    begin
                        state_next = S_TK_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDW'(1);
                        state_next = S_TK_RD;
                    end
                end
            end

            S_TK_FLUSH:
            begin
                // The result still held is the final one of the tick.
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (ob_ready)
                begin
                    ob_push         = 1'b1;
                    ob_res.last     = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            present_reg    <= '0;
            reload_lat_reg <= 1'b0;
            shut_lat_reg   <= 1'b0;
            warn_lat_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            rep_cnt_reg    <= '0;
            thr_reg        <= hwt_pkg::THRESHOLD_RESET;
            mode_reg       <= hwt_pkg::MODE_RELOAD;
            en_reg         <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            present_reg    <= present_next;
            reload_lat_reg <= reload_lat_next;
            shut_lat_reg   <= shut_lat_next;
            warn_lat_reg   <= warn_lat_next;
            hold_valid_reg <= hold_valid_next;
            rep_cnt_reg    <= rep_cnt_next;
            thr_reg        <= thr_next;
            mode_reg       <= mode_next;
            en_reg         <= en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hb_idx_reg <= in_idx;
        end
        if (hold_load)
        begin
            hold_reg <= hold_new;
        end
    end

    // Status RAM: running mark and miss counter per client.
    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_wa] <= stat_wd;
        end
        if (rd_en)
        begin
            stat_q <= stat_mem[rd_addr];
        end
    end

    // Process id RAM; written only by heartbeats.
    always_ff @(posedge clk)
    begin
        if (pid_we)
        begin
            pid_mem[in_idx] <= in_pid;
        end
        if (rd_en)
        begin
            pid_q <= pid_mem[rd_addr];
        end
    end

    hwt_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    hwt_obuf u_obuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (ob_push),
        .res           (ob_res),
        .ready         (ob_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/hwt_chk.sv -----
// Port-level checker of the heartbeat watchdog table and its bind statement.
// Depends on hwt_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hwt_chk
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic [hwt_pkg::TDATA_W-1:0] s_axis_tdata,
    input wire logic [0:0]                  s_axis_tuser,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [hwt_pkg::TDATA_W-1:0] m_axis_tdata,
    input wire logic                        m_axis_tlast,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic [1:0]                  cfg_index,
    input wire logic [7:0]                  cfg_data
);

    logic [hwt_pkg::ACT_W-1:0] out_act;
    logic                      out_xfer;
    logic                      hb_xfer;
    logic                      seen_reload_reg;
    logic                      seen_shut_reg;
    logic                      seen_warn_reg;

    assign out_act  = m_axis_tdata[hwt_pkg::OCL_W +: hwt_pkg::ACT_W];
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign hb_xfer  = s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser[0] == hwt_pkg::REQ_HEARTBEAT);

    // Each latched reaction may leave the block once after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reload_reg <= 1'b0;
            seen_shut_reg   <= 1'b0;
            seen_warn_reg   <= 1'b0;
        end
        else if (out_xfer)
        begin
            seen_reload_reg <= seen_reload_reg || (out_act == hwt_pkg::ACT_RELOAD);
            seen_shut_reg   <= seen_shut_reg || (out_act == hwt_pkg::ACT_SHUTDOWN);
            seen_warn_reg   <= seen_warn_reg || (out_act == hwt_pkg::ACT_WARNING);
        end
    end

    `HWT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    `HWT_ASSERT_NOW(a_no_accept_mid_tick, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    `HWT_ASSERT_NEXT(a_heartbeat_silent, hb_xfer, !$rose(m_axis_tvalid))

    `HWT_ASSERT_NOW(a_reaction_once, out_xfer,
        !(((out_act == hwt_pkg::ACT_RELOAD) && seen_reload_reg) ||
          ((out_act == hwt_pkg::ACT_SHUTDOWN) && seen_shut_reg) ||
          ((out_act == hwt_pkg::ACT_WARNING) && seen_warn_reg)))

endmodule

bind heartbeat_watchdog_table hwt_chk u_hwt_chk (.*);

`default_nettype wire

// ----- tb/heartbeat_watchdog_checker.sv -----
// Scoreboard for the heartbeat watchdog table: follows the configuration, input
// and result channels, predicts every expiry result and compares it field by field.
// Depends on hwt_pkg for the register indexes, request kinds, modes, actions and res_t.
`default_nettype none

module heartbeat_watchdog_checker
#(
    parameter int MODULES = 32
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tready,
    input  wire logic [hwt_pkg::TDATA_W-1:0] s_axis_tdata,
    input  wire logic [0:0]                  s_axis_tuser,
    input  wire logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic [hwt_pkg::TDATA_W-1:0] m_axis_tdata,
    input  wire logic                        m_axis_tlast,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [7:0]                  cfg_data,
    output int                               mismatches,
    output int                               outstanding
);
    import hwt_pkg::*;

    logic [CNT_W-1:0]  threshold;
    logic [MODE_W-1:0] mode;
    logic              enable;

    logic              present [MODULES];
    logic              running [MODULES];
    logic [CNT_W-1:0]  misses  [MODULES];
    logic [PID_W-1:0]  pid_of  [MODULES];
    logic              reload_held;
    logic              shutdown_held;
    logic              warning_held;

    res_t expiry_q[$];

    // Picks the reaction of an expiring client; each mode acts once, then only prompts.
    function automatic logic [ACT_W-1:0] react(input int id);
        logic [ACT_W-1:0] act;
        act = ACT_PROMPT;
        if (mode == MODE_RELOAD)
        begin
            if (running[id] && !reload_held)
            begin
                reload_held = 1'b1;
                act = ACT_RELOAD;
            end
        end
        else if (mode == MODE_SHUTDOWN)
        begin
            if (running[id] && !shutdown_held)
            begin
                shutdown_held = 1'b1;
                act = ACT_SHUTDOWN;
            end
        end
        else if (mode == MODE_WARNING)
        begin
            if (running[id] && !warning_held)
            begin
                warning_held = 1'b1;
                act = ACT_WARNING;
            end
        end
        running[id] = 1'b0;
        return act;
    endfunction

    task automatic note_heartbeat(input logic [CID_W-1:0] cid, input logic [PID_W-1:0] pid);
        if (cid != 0 && int'(cid) < MODULES)
        begin
            if (!present[cid])
            begin
                present[cid] = 1'b1;
                running[cid] = 1'b1;
            end
            pid_of[cid] = pid;
            misses[cid] = '0;
        end
    endtask

    // When enabled, walks all clients in ascending order and queues one result per wrap.
    task automatic advance_tick();
        res_t batch[$];
        res_t r;
        int   thr;
        int   nxt;
        if (!enable)
            return;
        thr = (threshold == 0) ? 1 : int'(threshold);
        for (int id = 1; id < MODULES; id++)
        begin
            if (present[id])
            begin
                nxt = (int'(misses[id]) + 1) % thr;
                misses[id] = nxt[CNT_W-1:0];
                if (nxt == 0)
                begin
                    r.action          = react(id);
                    r.expired_client  = id[OCL_W-1:0];
                    r.expired_proc_id = pid_of[id];
                    r.last            = 1'b0;
                    if (batch.size() < MAX_RESULTS)
                        batch.push_back(r);
                end
            end
        end
        if (batch.size() > 0)
        begin
            r = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
        end
        foreach (batch[k])
            expiry_q.push_back(batch[k]);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input logic [TDATA_W-1:0] data, input logic tlast_bit);
        res_t want;
        if (expiry_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result: expected none, actual client %0d action %0d pid 0x%0h last %0b",
                     $time, data[4:0], data[6:5], data[28:7], tlast_bit);
        end
        else
        begin
            want = expiry_q.pop_front();
            compare_field("expired_client", want.expired_client, data[4:0]);
            compare_field("action", want.action, data[6:5]);
            compare_field("expired_proc_id", want.expired_proc_id, data[28:7]);
            compare_field("padding", 0, data[TDATA_W-1:29]);
            compare_field("last", want.last, tlast_bit);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold     = THRESHOLD_RESET;
            mode          = MODE_RELOAD;
            enable        = 1'b1;
            reload_held   = 1'b0;
            shutdown_held = 1'b0;
            warning_held  = 1'b0;
            for (int id = 0; id < MODULES; id++)
            begin
                present[id] = 1'b0;
                running[id] = 1'b0;
                misses[id]  = '0;
                pid_of[id]  = '0;
            end
            expiry_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // Results leaving now belong to earlier ticks, so compare before predicting.
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata, m_axis_tlast);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD: threshold = cfg_data;
                    REG_MODE:      mode      = cfg_data[MODE_W-1:0];
                    REG_ENABLE:    enable    = cfg_data[0];
                    default:       ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == REQ_HEARTBEAT)
                    note_heartbeat(s_axis_tdata[7:0], s_axis_tdata[29:8]);
                else
                    advance_tick();
            end
            outstanding = expiry_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/heartbeat_watchdog_table_test.sv -----
// Top of the heartbeat watchdog table testbench: clock, reset, stimulus and verdict.
// Depends on hwt_pkg, the block heartbeat_watchdog_table and heartbeat_watchdog_checker.
`default_nettype none

module heartbeat_watchdog_table_test;
    import hwt_pkg::*;

    localparam int MODULES       = 32;
    // A tick with every client present reads and writes back each entry; entries that
    // use the remainder unit also wait for it. This covers a tick that sends nothing.
    localparam int DRAIN_CYCLES  = 12 * MODULES + 16;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 32;
    localparam int PID_MAX       = (1 << PID_W) - 1;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index     = '0;
    logic [7:0]          cfg_data      = '0;

    int   mismatches;
    int   outstanding;
    int   cycles   = 0;
    int   rx_hold  = 0;
    // When set, the matching side runs without any idle cycles for the current phase.
    logic tx_quiet = 1'b0;
    logic rx_quiet = 1'b0;

    heartbeat_watchdog_table #(.MODULES(MODULES)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    heartbeat_watchdog_checker #(.MODULES(MODULES)) scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle lengths: mostly none or a few cycles, now and then a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // The result side stalls at random. After every cycle with tready high a new
    // stall length is drawn, so back-pressure can land on any result of a tick.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end
        else if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold       <= rx_quiet ? 0 : pick_gap();
        end
    end

    // Watchdog on the whole run, in case the block hangs or a handshake never comes.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Presents one input transfer and returns at the edge that accepts it. tvalid is
    // left high, so the next transfer can follow in the very next cycle; a gap lowers
    // it first. Either way tvalid gets only one assignment per time step.
    task automatic send_transfer(input logic typ, input logic [CID_W-1:0] cid,
                                 input logic [PID_W-1:0] pid);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= typ;
        s_axis_tdata  <= {2'b00, pid, cid};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic heartbeat(input logic [CID_W-1:0] cid, input logic [PID_W-1:0] pid);
        send_transfer(REQ_HEARTBEAT, cid, pid);
    endtask

    // Ticks carry random client and process fields, which the block must ignore.
    task automatic tick();
        send_transfer(REQ_TICK, $urandom_range(0, 255), $urandom_range(0, PID_MAX));
    endtask

    // Stops the input and waits until every predicted result has been seen. The
    // first edge makes sure the checker has already counted the last accepted tick.
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // A tick can still be walking entries that send nothing after its last result,
    // so the block gets a full walk worth of cycles before it counts as idle.
    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Writes all three registers back to back; only called while the block is idle.
    task automatic configure(input logic [CNT_W-1:0] thr, input logic [MODE_W-1:0] md,
                             input logic en);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MODE, {6'b0, md});
        write_reg(REG_ENABLE, {7'b0, en});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CNT_W-1:0]  thr;
        logic [MODE_W-1:0] md;
        logic              en;
        int                r;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Start from the reset values, written explicitly.
        configure(THRESHOLD_RESET, MODE_RELOAD, 1'b1);

        // Extreme ids and process ids; id zero and ids at or above MODULES are dropped.
        // The second heartbeat of client 1 only updates its process id.
        heartbeat(8'd1, '0);
        heartbeat(8'd31, PID_MAX);
        heartbeat(8'd0, 22'h2AAAAA);
        heartbeat(8'd32, 22'h155555);
        heartbeat(8'd255, PID_MAX);
        heartbeat(8'd1, 22'h155555);
        // Third tick expires both: client 1 reloads, client 31 only prompts since the
        // reload latch is already taken.
        repeat (3) tick();

        // A zero threshold acts as one: every tick expires every client. The new
        // client 5 takes the shutdown; the second tick finds nobody running.
        settle();
        configure(8'd0, MODE_SHUTDOWN, 1'b1);
        heartbeat(8'd5, 22'h3C3C3C);
        repeat (2) tick();

        // With the watchdog off a tick does nothing, while heartbeats still register.
        settle();
        configure(8'd255, MODE_WARNING, 1'b0);
        heartbeat(8'd7, 22'h0F0F0F);
        tick();

        // Largest threshold: counters climb to five without expiring.
        settle();
        configure(8'd255, MODE_WARNING, 1'b1);
        repeat (5) tick();

        // Lowering the threshold below the counters: (5 + 1) mod 2 wraps everyone,
        // and client 7, still running, takes the warning.
        settle();
        configure(8'd2, MODE_WARNING, 1'b1);
        tick();

        // The unused mode prompts even for a client that is running.
        settle();
        configure(8'd2, 2'd3, 1'b1);
        heartbeat(8'd9, 22'h123456);
        repeat (2) tick();

        // Random part. Each phase draws a new configuration, mostly small thresholds
        // so that expiries are frequent, with zero and the maximum now and then.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            r = $urandom_range(0, 99);
            if (r < 15)
                thr = 8'd0;
            else if (r < 30)
                thr = 8'd1;
            else if (r < 40)
                thr = 8'd255;
            else
                thr = $urandom_range(2, 6);
            md = $urandom_range(0, 3);
            en = ($urandom_range(0, 9) != 0);
            configure(thr, md, en);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Let the result side run dry in the middle of a phase at least once.
                if (i == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 2) == 0))
                    wait_results();
                r = $urandom_range(0, 99);
                if (r < 50)
                    heartbeat($urandom_range(1, MODULES - 1), $urandom_range(0, PID_MAX));
                else if (r < 56)
                    heartbeat($urandom_range(0, 255), $urandom_range(0, PID_MAX));
                else
                    tick();
            end
        end

        settle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
